[hdl/cdb_pkg.sv]
// Shared constants, types and index helpers for the circular deque buffer.
package cdb_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int CAPX_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_DUMP       = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DUMPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Pointer update requested by the controller.
	typedef struct packed {
		logic push_en;
		logic at_front;
	} ptr_cmd_t;

	// Pointer status seen by the controller.
	typedef struct packed {
		logic              empty;
		logic              full;
		logic [IDX_W-1:0]  front;
		logic [IDX_W-1:0]  front_slot;
		logic [IDX_W-1:0]  rear_slot;
		logic [CNT_W-1:0]  count;
		logic [CAPX_W-1:0] cap;
	} ptr_info_t;

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] idx,
		input logic [CAPX_W-1:0] cap);
		logic [CAPX_W:0] n;
		n = (CAPX_W+1)'(idx) + (CAPX_W+1)'(1);
		return (n == (CAPX_W+1)'(cap)) ? '0 : IDX_W'(n);
	endfunction

	function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] idx,
		input logic [CAPX_W-1:0] cap);
		return (idx == '0) ? IDX_W'(cap - CAPX_W'(1)) : idx - IDX_W'(1);
	endfunction

endpackage

[hdl/cdb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module cdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/cdb_ptr.sv]
// Front and rear pointers, empty flag, capacity register and derived status.
module cdb_ptr
	import cdb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  ptr_cmd_t         cmd,
	output ptr_info_t        info
);

	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  front_q;
	logic [IDX_W-1:0]  rear_q;
	logic              empty_q;
	logic [CAPX_W-1:0] cap_raw;
	logic [CAPX_W-1:0] cap_eff;
	logic [IDX_W-1:0]  front_prev;
	logic [IDX_W-1:0]  rear_next;
	logic [CAPX_W:0]   span;

	always_comb begin
		cap_raw = CAPX_W'(cap_q);
		if (cap_raw == '0) begin
			cap_eff = CAPX_W'(1);
		end else if ((CAPX_W+1)'(cap_raw) > (CAPX_W+1)'(DEPTH)) begin
			cap_eff = CAPX_W'(DEPTH);
		end else begin
			cap_eff = cap_raw;
		end
	end

	assign front_prev = dec_wrap(front_q, cap_eff);
	assign rear_next  = inc_wrap(rear_q, cap_eff);

	// Occupancy is the wrapped distance from front to rear, plus one.
	always_comb begin
		if (rear_q >= front_q) begin
			span = (CAPX_W+1)'(rear_q) - (CAPX_W+1)'(front_q) + (CAPX_W+1)'(1);
		end else begin
			span = (CAPX_W+1)'(rear_q) + (CAPX_W+1)'(cap_eff)
				- (CAPX_W+1)'(front_q) + (CAPX_W+1)'(1);
		end
	end

	always_comb begin
		info.empty      = empty_q;
		info.full       = !empty_q && (rear_next == front_q);
		info.front      = front_q;
		info.front_slot = empty_q ? front_q : front_prev;
		info.rear_slot  = empty_q ? front_q : rear_next;
		info.count      = CNT_W'(span);
		info.cap        = cap_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr_en) begin
			// A new capacity empties the buffer.
			cap_q   <= cfg_wr_data;
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.push_en) begin
			if (empty_q) begin
				rear_q  <= front_q;
				empty_q <= 1'b0;
			end else if (cmd.at_front) begin
				front_q <= front_prev;
			end else begin
				rear_q <= rear_next;
			end
		end
	end

endmodule

[hdl/circular_deque_buffer.sv]
// A push or an empty dump gives its result in the cycle after acceptance.
// One push per cycle while the output is not stalled. A dump holds off input until its
// last word is out; the first slot read overlaps acceptance, and words stream one per cycle.
// Output stalls back up into the input through the single result register.
// Reset empties the buffer and sets the capacity to 16; slot contents are not
// cleared, since only written slots are ever read.
module circular_deque_buffer
	import cdb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         queue_capacity,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic [1:0]               status,
	output logic                     last
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t                   state_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	status_t                  status_q;
	logic                     last_q;
	logic [IDX_W-1:0]         pos_q;
	logic [CNT_W-1:0]         cnt_q;

	ptr_cmd_t         pcmd;
	ptr_info_t        pinfo;
	cmd_t             cmd;
	logic             out_free;
	logic             take;
	logic             dump_last;
	logic [IDX_W-1:0] pos_next;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;

	assign cmd       = cmd_t'(command);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign take      = in_valid && !in_stall;
	assign dump_last = (cnt_q == CNT_W'(1));
	assign pos_next  = inc_wrap(pos_q, pinfo.cap);

	// A dump only starts once the previous push has been written, and pushes are
	// held off during a dump, so reads never meet a write to the same slot.
	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = pinfo.rear_slot;
		rd_en         = 1'b0;
		rd_addr       = pinfo.front;
		pcmd.push_en  = 1'b0;
		pcmd.at_front = (cmd == CMD_PUSH_FRONT);
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (cmd)
						CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
							wr_en        = !pinfo.full;
							wr_addr      = (cmd == CMD_PUSH_FRONT) ? pinfo.front_slot
								: pinfo.rear_slot;
							pcmd.push_en = !pinfo.full;
						end
						CMD_DUMP: begin
							rd_en = !pinfo.empty;
						end
						default: begin
						end
					endcase
				end
			end
			S_DUMP: begin
				rd_addr = pos_next;
				rd_en   = out_free && !dump_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			status_q    <= ST_ACCEPTED;
			last_q      <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (cmd)
							CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
								out_valid_q <= 1'b1;
								out_value_q <= '0;
								status_q    <= pinfo.full ? ST_FULL : ST_ACCEPTED;
								last_q      <= 1'b1;
							end
							CMD_DUMP: begin
								if (pinfo.empty) begin
									out_valid_q <= 1'b1;
									out_value_q <= '0;
									status_q    <= ST_EMPTY;
									last_q      <= 1'b1;
								end else begin
									pos_q   <= pinfo.front;
									cnt_q   <= pinfo.count;
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= $signed(rd_data);
						status_q    <= ST_DUMPED;
						last_q      <= dump_last;
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_next;
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign last      = last_q;

	cdb_ptr u_ptr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (queue_capacity),
		.cmd         (pcmd),
		.info        (pinfo)
	);

	cdb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
